// ===== sv/assert_macros.svh =====
// Assertion helpers used by circle_span_rasterizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("csr: assertion failed");
`define CSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csr: assertion failed");
`else
`define CSR_ASSERT(lbl, clk, rst_n, prop)
`define CSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/csr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csr_pkg;

  localparam int unsigned COORD_BITS_DEF  = 12;
  localparam int unsigned RADIUS_BITS_DEF = 11;
  localparam int unsigned OUT_W           = 14;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [1:0] MODE_DISC = 2'd1;
  localparam logic [1:0] MODE_RING = 2'd2;

  localparam int unsigned SHAPE_W = 3;
  localparam logic [SHAPE_W-1:0] SHAPE_POINT     = 3'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_OUTLINE   = 3'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_DISC      = 3'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_RING_IN   = 3'd3;
  localparam logic [SHAPE_W-1:0] SHAPE_RING_FULL = 3'd4;

  typedef struct packed {
    logic               start;
    logic [SHAPE_W-1:0] shape;
    logic               done;
  } emit_ctl_t;

  typedef struct packed {
    logic busy;
    logic fin;
  } emit_sts_t;

  function automatic logic [3:0] seg_count(input logic [SHAPE_W-1:0] shape);
    logic [3:0] n;
    case (shape)
      SHAPE_POINT:     n = 4'd1;
      SHAPE_OUTLINE:   n = 4'd8;
      SHAPE_DISC:      n = 4'd4;
      SHAPE_RING_IN:   n = 4'd4;
      SHAPE_RING_FULL: n = 4'd2;
      default:         n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== sv/csr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface csr_in_if #(
  parameter int unsigned COORD_BITS  = csr_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = csr_pkg::RADIUS_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] outer_radius;
  logic [RADIUS_BITS-1:0] hole_radius;
  logic [1:0]             mode;

  modport source (
    output valid, cmd, center_x, center_y, outer_radius, hole_radius, mode,
    input  ready
  );
  modport sink (
    input  valid, cmd, center_x, center_y, outer_radius, hole_radius, mode,
    output ready
  );
endinterface

interface csr_out_if ();
  logic                               valid;
  logic                               ready;
  logic signed [csr_pkg::OUT_W-1:0]   x_start;
  logic signed [csr_pkg::OUT_W-1:0]   y_start;
  logic signed [csr_pkg::OUT_W-1:0]   x_end;
  logic signed [csr_pkg::OUT_W-1:0]   y_end;
  logic                               last;
  logic                               done_res;

  modport source (
    output valid, x_start, y_start, x_end, y_end, last, done_res,
    input  ready
  );
  modport sink (
    input  valid, x_start, y_start, x_end, y_end, last, done_res,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/csr_square.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial shift-add squarer, one multiplier bit per cycle.
module csr_square #(
  parameter int unsigned RADIUS_BITS = csr_pkg::RADIUS_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [RADIUS_BITS-1:0]   a_i,
  output logic                     done_o,
  output logic [2*RADIUS_BITS-1:0] sq_o
);

  localparam int unsigned RB    = RADIUS_BITS;
  localparam int unsigned PW    = 2 * RB;
  localparam int unsigned CNT_W = $clog2(RB);

  logic [PW-1:0]    mcand_q, mcand_d;
  logic [RB-1:0]    mplier_q, mplier_d;
  logic [PW-1:0]    acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             fin_q, fin_d;
  logic             last_it;

  assign last_it = (cnt_q == CNT_W'(RB - 1));

  always_comb begin
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    run_d    = run_q;
    fin_d    = 1'b0;
    if (start_i) begin
      mcand_d  = PW'(a_i);
      mplier_d = a_i;
      acc_d    = '0;
      cnt_d    = '0;
      run_d    = 1'b1;
    end else if (run_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[PW-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[RB-1:1]};
      cnt_d    = cnt_q + CNT_W'(1);
      if (last_it) begin
        run_d = 1'b0;
        fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcand_q  <= '0;
      mplier_q <= '0;
      acc_q    <= '0;
      cnt_q    <= '0;
      run_q    <= 1'b0;
      fin_q    <= 1'b0;
    end else begin
      mcand_q  <= mcand_d;
      mplier_q <= mplier_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      run_q    <= run_d;
      fin_q    <= fin_d;
    end
  end

  assign done_o = fin_q;
  assign sq_o   = acc_q;

endmodule

`default_nettype wire

// ===== sv/csr_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring square root, two radicand bits per cycle, rounded to nearest.
module csr_sqrt #(
  parameter int unsigned RADIUS_BITS = csr_pkg::RADIUS_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [2*RADIUS_BITS-1:0] value_i,
  output logic                     done_o,
  output logic [RADIUS_BITS-1:0]   root_o
);

  localparam int unsigned RB    = RADIUS_BITS;
  localparam int unsigned VW    = 2 * RB;
  localparam int unsigned REM_W = RB + 3;
  localparam int unsigned CNT_W = $clog2(RB);

  logic [VW-1:0]    val_q, val_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [RB-1:0]    root_q, root_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             fin_q, fin_d;
  logic [REM_W-1:0] rem_sh, trial;
  logic             ge, rnd;

  assign rem_sh = {rem_q[REM_W-3:0], val_q[VW-1:VW-2]};
  assign trial  = REM_W'({root_q, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    fin_d  = 1'b0;
    if (start_i) begin
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      val_d  = {val_q[VW-3:0], 2'b00};
      rem_d  = ge ? (rem_sh - trial) : rem_sh;
      root_d = {root_q[RB-2:0], ge};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(RB - 1)) begin
        run_d = 1'b0;
        fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      val_q  <= val_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      fin_q  <= fin_d;
    end
  end

  // remainder above root means the true root lies past the half point
  assign rnd    = (rem_q > REM_W'(root_q));
  assign root_o = root_q + RB'(rnd);
  assign done_o = fin_q;

endmodule

`default_nettype wire

// ===== sv/csr_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Walks the segment list of one row and drives the output register.
module csr_emit #(
  parameter int unsigned COORD_BITS  = csr_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = csr_pkg::RADIUS_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  csr_pkg::emit_ctl_t     ctl_i,
  input  logic [COORD_BITS-1:0]  cx_i,
  input  logic [COORD_BITS-1:0]  cy_i,
  input  logic [RADIUS_BITS:0]   y_i,
  input  logic [RADIUS_BITS-1:0] xo_i,
  input  logic [RADIUS_BITS-1:0] xi_i,
  output csr_pkg::emit_sts_t     sts_o,
  csr_out_if.source              out_o
);

  localparam int unsigned OW = csr_pkg::OUT_W;

  logic [OW-1:0] cxw, cyw, tyw, tow, tiw;
  logic [OW-1:0] xpy, xmy, xpo, xmo, xpi, xmi, ymy, ypy, ymo, ypo;
  logic [OW-1:0] xs_c, ys_c, xe_c, ye_c;

  logic                        busy_q, busy_d;
  logic [2:0]                  k_q, k_d;
  logic [csr_pkg::SHAPE_W-1:0] shape_q, shape_d;
  logic                        done_q, done_d;
  logic                        ov_q, ov_d;
  logic [OW-1:0]               xs_q, ys_q, xe_q, ye_q;
  logic                        last_q, dres_q;
  logic [3:0]                  cnt_m1;
  logic                        is_last, load;

  assign cxw = OW'(cx_i);
  assign cyw = OW'(cy_i);
  assign tyw = OW'(y_i);
  assign tow = OW'(xo_i);
  assign tiw = OW'(xi_i);

  assign xpy = cxw + tyw;
  assign xmy = cxw - tyw;
  assign xpo = cxw + tow;
  assign xmo = cxw - tow;
  assign xpi = cxw + tiw;
  assign xmi = cxw - tiw;
  assign ymy = cyw - tyw;
  assign ypy = cyw + tyw;
  assign ymo = cyw - tow;
  assign ypo = cyw + tow;

  always_comb begin
    xs_c = cxw;
    ys_c = cyw;
    xe_c = cxw;
    ye_c = cyw;
    case (shape_q)
      csr_pkg::SHAPE_OUTLINE: begin
        case (k_q)
          3'd0: begin xs_c = xpy; ys_c = ymo; end
          3'd1: begin xs_c = xpo; ys_c = ymy; end
          3'd2: begin xs_c = xpo; ys_c = ypy; end
          3'd3: begin xs_c = xpy; ys_c = ypo; end
          3'd4: begin xs_c = xmy; ys_c = ypo; end
          3'd5: begin xs_c = xmo; ys_c = ypy; end
          3'd6: begin xs_c = xmo; ys_c = ymy; end
          default: begin xs_c = xmy; ys_c = ymo; end
        endcase
        xe_c = xs_c;
        ye_c = ys_c;
      end
      csr_pkg::SHAPE_DISC: begin
        case (k_q)
          3'd0: begin xs_c = xpy; ys_c = ymo; xe_c = xmy; ye_c = ymo; end
          3'd1: begin xs_c = xpo; ys_c = ymy; xe_c = xmo; ye_c = ymy; end
          3'd2: begin xs_c = xpo; ys_c = ypy; xe_c = xmo; ye_c = ypy; end
          default: begin xs_c = xpy; ys_c = ypo; xe_c = xmy; ye_c = ypo; end
        endcase
      end
      csr_pkg::SHAPE_RING_IN: begin
        case (k_q)
          3'd0: begin xs_c = xmo; ys_c = ymy; xe_c = xmi; ye_c = ymy; end
          3'd1: begin xs_c = xpi; ys_c = ymy; xe_c = xpo; ye_c = ymy; end
          3'd2: begin xs_c = xmi; ys_c = ypy; xe_c = xmo; ye_c = ypy; end
          default: begin xs_c = xpi; ys_c = ypy; xe_c = xpo; ye_c = ypy; end
        endcase
      end
      csr_pkg::SHAPE_RING_FULL: begin
        case (k_q)
          3'd0: begin xs_c = xmo; ys_c = ymy; xe_c = xpo; ye_c = ymy; end
          default: begin xs_c = xmo; ys_c = ypy; xe_c = xpo; ye_c = ypy; end
        endcase
      end
      default: begin
        xs_c = cxw;
        ys_c = cyw;
        xe_c = cxw;
        ye_c = cyw;
      end
    endcase
  end

  assign cnt_m1  = csr_pkg::seg_count(shape_q) - 4'd1;
  assign is_last = ({1'b0, k_q} == cnt_m1);
  assign load    = busy_q && (!ov_q || out_o.ready);

  always_comb begin
    busy_d  = busy_q;
    k_d     = k_q;
    shape_d = shape_q;
    done_d  = done_q;
    ov_d    = ov_q;
    if (ctl_i.start) begin
      busy_d  = 1'b1;
      k_d     = '0;
      shape_d = ctl_i.shape;
      done_d  = ctl_i.done;
    end else if (load) begin
      k_d = k_q + 3'd1;
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      k_q     <= '0;
      shape_q <= csr_pkg::SHAPE_POINT;
      done_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      k_q     <= k_d;
      shape_q <= shape_d;
      done_q  <= done_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      xs_q   <= xs_c;
      ys_q   <= ys_c;
      xe_q   <= xe_c;
      ye_q   <= ye_c;
      last_q <= is_last;
      dres_q <= is_last && done_q;
    end
  end

  assign out_o.valid    = ov_q;
  assign out_o.x_start  = xs_q;
  assign out_o.y_start  = ys_q;
  assign out_o.x_end    = xe_q;
  assign out_o.y_end    = ye_q;
  assign out_o.last     = last_q;
  assign out_o.done_res = dres_q;

  assign sts_o.busy = busy_q;
  assign sts_o.fin  = load && is_last;

endmodule

`default_nettype wire

// ===== sv/circle_span_rasterizer.sv =====
// Circle, disc and ring rasterizer, one row offset per step word.
// in_i carries command words: cmd start latches center, radii (inner
// clamped to outer) and mode and returns no output word; cmd step emits
// the segments of the current row and advances the row. A step with no
// figure in progress is consumed and produces nothing.
// out_o carries segment words; last marks the final word of a step and
// done_res the final word of the figure, after which steps are ignored
// until the next start.
// A start keeps in_i.ready low while the bit-serial squarers form both
// radius squares. A step passes through the two-bits-per-cycle square
// root units (next row half widths), then moves one segment word (1 to
// 8) per cycle into the output register while the receiver takes them.
// One word is worked at a time. A stalled receiver holds the output
// register and the segment walk; in_i.ready rises again once the last
// word of the step sits in the output register.
// Reset clears all held figure state; no figure is active after reset.
`timescale 1ns / 1ps
`default_nettype none

module circle_span_rasterizer #(
  parameter int unsigned COORD_BITS  = csr_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = csr_pkg::RADIUS_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csr_in_if.sink     in_i,
  csr_out_if.source  out_o
);

`include "assert_macros.svh"

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned RB    = RADIUS_BITS;
  localparam int unsigned Y_W   = RB + 1;
  localparam int unsigned SQ_W  = 2 * RB;
  localparam int unsigned YSQ_W = 2 * RB + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SQUARE = 2'd1;
  localparam logic [1:0] ST_ROOT   = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic             active_q, active_d;
  logic [CB-1:0]    cx_q, cx_d, cy_q, cy_d;
  logic [RB-1:0]    ro_q, ro_d, ri_q, ri_d;
  logic [1:0]       mode_q, mode_d;
  logic [Y_W-1:0]   y_q, y_d;
  logic [YSQ_W-1:0] ysq_q, ysq_d;
  logic [RB-1:0]    xo_q, xo_d, xi_q, xi_d;
  logic [SQ_W-1:0]  rsqo_q, rsqo_d, rsqi_q, rsqi_d;
  logic [RB-1:0]    hwo_q, hwo_d, hwi_q, hwi_d;
  logic             done_q, done_d;

  logic             in_ready, acc, start_acc, step_acc;
  logic [RB-1:0]    ri_clamp;
  logic             sqo_done, sqi_done;
  logic [SQ_W-1:0]  sqo, sqi;
  logic [Y_W-1:0]   y_next;
  logic [YSQ_W-1:0] ysq_n;
  logic             ovf_o, ovf_i;
  logic [SQ_W-1:0]  v_o, v_i;
  logic             rto_done, rti_done;
  logic [RB-1:0]    rto, rti;
  logic             done_c;
  logic [csr_pkg::SHAPE_W-1:0] shape_c;

  csr_pkg::emit_ctl_t emit_ctl;
  csr_pkg::emit_sts_t emit_sts;

  assign in_ready   = (state_q == ST_IDLE);
  assign in_i.ready = in_ready;
  assign acc        = in_i.valid && in_ready;
  assign start_acc  = acc && (in_i.cmd == csr_pkg::CMD_START);
  assign step_acc   = acc && (in_i.cmd == csr_pkg::CMD_STEP) && active_q;

  assign ri_clamp = (in_i.hole_radius > in_i.outer_radius) ? in_i.outer_radius
                                                           : in_i.hole_radius;

  csr_square #(.RADIUS_BITS(RB)) u_sq_outer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_acc),
    .a_i     (in_i.outer_radius),
    .done_o  (sqo_done),
    .sq_o    (sqo)
  );

  csr_square #(.RADIUS_BITS(RB)) u_sq_inner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_acc),
    .a_i     (ri_clamp),
    .done_o  (sqi_done),
    .sq_o    (sqi)
  );

  // (y+1)^2 = y^2 + 2y + 1
  assign y_next = y_q + Y_W'(1);
  assign ysq_n  = ysq_q + YSQ_W'({y_q, 1'b1});
  assign ovf_o  = (y_next > Y_W'(ro_q));
  assign ovf_i  = (y_next > Y_W'(ri_q));
  assign v_o    = ovf_o ? '0 : (rsqo_q - ysq_n[SQ_W-1:0]);
  assign v_i    = ovf_i ? '0 : (rsqi_q - ysq_n[SQ_W-1:0]);

  csr_sqrt #(.RADIUS_BITS(RB)) u_rt_outer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (step_acc),
    .value_i (v_o),
    .done_o  (rto_done),
    .root_o  (rto)
  );

  csr_sqrt #(.RADIUS_BITS(RB)) u_rt_inner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (step_acc),
    .value_i (v_i),
    .done_o  (rti_done),
    .root_o  (rti)
  );

  always_comb begin
    if (mode_q == csr_pkg::MODE_RING) begin
      done_c = (y_q >= Y_W'(ro_q));
    end else begin
      done_c = ovf_o || (Y_W'(rto) < y_next);
    end
    if (ro_q == '0) begin
      shape_c = csr_pkg::SHAPE_POINT;
    end else if (mode_q == csr_pkg::MODE_RING) begin
      shape_c = (y_q <= Y_W'(ri_q)) ? csr_pkg::SHAPE_RING_IN : csr_pkg::SHAPE_RING_FULL;
    end else if (mode_q == csr_pkg::MODE_DISC) begin
      shape_c = csr_pkg::SHAPE_DISC;
    end else begin
      shape_c = csr_pkg::SHAPE_OUTLINE;
    end
  end

  assign emit_ctl.start = (state_q == ST_ROOT) && rto_done;
  assign emit_ctl.shape = shape_c;
  assign emit_ctl.done  = done_c;

  csr_emit #(.COORD_BITS(CB), .RADIUS_BITS(RB)) u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (emit_ctl),
    .cx_i   (cx_q),
    .cy_i   (cy_q),
    .y_i    (y_q),
    .xo_i   (xo_q),
    .xi_i   (xi_q),
    .sts_o  (emit_sts),
    .out_o  (out_o)
  );

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    ro_d     = ro_q;
    ri_d     = ri_q;
    mode_d   = mode_q;
    y_d      = y_q;
    ysq_d    = ysq_q;
    xo_d     = xo_q;
    xi_d     = xi_q;
    rsqo_d   = rsqo_q;
    rsqi_d   = rsqi_q;
    hwo_d    = hwo_q;
    hwi_d    = hwi_q;
    done_d   = done_q;
    case (state_q)
      ST_IDLE: begin
        if (start_acc) begin
          cx_d     = in_i.center_x;
          cy_d     = in_i.center_y;
          ro_d     = in_i.outer_radius;
          ri_d     = ri_clamp;
          mode_d   = in_i.mode;
          y_d      = '0;
          ysq_d    = '0;
          xo_d     = in_i.outer_radius;
          xi_d     = ri_clamp;
          active_d = 1'b1;
          state_d  = ST_SQUARE;
        end else if (step_acc) begin
          ysq_d   = ysq_n;
          state_d = ST_ROOT;
        end
      end
      ST_SQUARE: begin
        if (sqo_done) begin
          rsqo_d  = sqo;
          rsqi_d  = sqi;
          state_d = ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (rto_done) begin
          hwo_d   = rto;
          hwi_d   = rti;
          done_d  = done_c;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_sts.fin) begin
          y_d      = y_next;
          xo_d     = hwo_q;
          xi_d     = hwi_q;
          active_d = !done_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= 1'b0;
      cx_q     <= '0;
      cy_q     <= '0;
      ro_q     <= '0;
      ri_q     <= '0;
      mode_q   <= '0;
      y_q      <= '0;
      ysq_q    <= '0;
      xo_q     <= '0;
      xi_q     <= '0;
      rsqo_q   <= '0;
      rsqi_q   <= '0;
      hwo_q    <= '0;
      hwi_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      ro_q     <= ro_d;
      ri_q     <= ri_d;
      mode_q   <= mode_d;
      y_q      <= y_d;
      ysq_q    <= ysq_d;
      xo_q     <= xo_d;
      xi_q     <= xi_d;
      rsqo_q   <= rsqo_d;
      rsqi_q   <= rsqi_d;
      hwo_q    <= hwo_d;
      hwi_q    <= hwi_d;
      done_q   <= done_d;
    end
  end

  `CSR_ASSERT(a_squares_aligned, clk_i, rst_ni, sqo_done == sqi_done)
  `CSR_ASSERT(a_roots_aligned, clk_i, rst_ni, rto_done == rti_done)
  `CSR_ASSERT(a_root_in_root, clk_i, rst_ni, !rto_done || (state_q == ST_ROOT))
  `CSR_ASSERT(a_fin_in_emit, clk_i, rst_ni, !emit_sts.fin || (state_q == ST_EMIT))
  `CSR_ASSERT(a_inner_le_outer, clk_i, rst_ni, xi_q <= xo_q)
  `CSR_ASSERT_NEXT(a_done_clears, clk_i, rst_ni, emit_sts.fin && done_q, !active_q)

endmodule

`default_nettype wire
